// ----- hdl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_RCP = 3'd4;
  localparam logic [2:0] MODE_ABS = 3'd5;
  localparam logic [2:0] MODE_POW = 3'd6;
  localparam logic [2:0] MODE_CMP = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam int DATA_W = 136;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_GCD
  } iter_op_t;

  typedef struct packed {
    logic     go;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } iter_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_M1,
    S_M2,
    S_M3,
    S_ADD,
    S_CMP,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_PPREP,
    S_PCHK,
    S_PMN,
    S_PMD,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ----- hdl/rau_iter.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, binary gcd.
`timescale 1ns / 1ps
module rau_iter #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::iter_req_t  req,
  input  logic [63:0]         x,
  input  logic [63:0]         y,
  output rau_pkg::iter_rsp_t  rsp,
  output logic [63:0]         res
);
  import rau_pkg::*;

  logic            busy;
  logic            done;
  iter_op_t        op;
  logic [63:0]     acc;
  logic [63:0]     sh;
  logic [63:0]     opr;
  logic [6:0]      cnt;
  logic [5:0]      k;

  logic [64:0]     msum;
  logic [64:0]     rsh;
  logic [64:0]     rdiff;
  logic            rge;
  logic [64+W-1:0] prod;

  assign msum  = {1'b0, acc} + (sh[0] ? {1'b0, opr} : 65'd0);
  assign rsh   = {acc, sh[63]};
  assign rge   = rsh >= {1'b0, opr};
  assign rdiff = rsh - {1'b0, opr};
  assign prod  = {acc, sh[63:64-W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.go && !done) begin
          busy <= 1'b1;
          op   <= req.op;
          cnt  <= 7'd0;
          k    <= 6'd0;
          case (req.op)
            OP_MUL: begin
              acc <= 64'd0;
              sh  <= 64'(y[W-1:0]);
              opr <= x;
            end
            OP_DIV: begin
              acc <= 64'd0;
              sh  <= x;
              opr <= y;
            end
            default: begin
              if (y == 64'd0) begin
                acc <= 64'd0;
                opr <= x;
              end else begin
                acc <= x;
                opr <= y;
              end
            end
          endcase
        end
      end else begin
        case (op)
          OP_MUL: begin
            acc <= msum[64:1];
            sh  <= {msum[0], sh[63:1]};
            cnt <= cnt + 7'd1;
            if (cnt == 7'(W - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_DIV: begin
            acc <= rge ? rdiff[63:0] : rsh[63:0];
            sh  <= {sh[62:0], rge};
            cnt <= cnt + 7'd1;
            if (cnt == 7'd63) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            if (acc == 64'd0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else if (!acc[0] && !opr[0]) begin
              acc <= acc >> 1;
              opr <= opr >> 1;
              k   <= k + 6'd1;
            end else if (!acc[0]) begin
              acc <= acc >> 1;
            end else if (!opr[0]) begin
              opr <= opr >> 1;
            end else if (acc >= opr) begin
              acc <= acc - opr;
            end else begin
              opr <= opr - acc;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    case (op)
      OP_MUL:  res = prod[63:0];
      OP_DIV:  res = sh;
      default: res = opr << k;
    endcase
  end

  assign rsp.done = done;
  assign rsp.ovf  = (op == OP_MUL) && (|prod[64+W-1:64]);

endmodule

// ----- hdl/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit: sequencer around one shared multiply/divide/gcd unit.
// Each item runs as a sequence of multiply steps, divide steps and binary gcd steps
// on the shared unit; a reduce is one gcd and two divides.
// Power mode adds one reduce, plus two multiplies and a check per unit of exponent.
// One item at a time: a new item is taken only when the sequencer is idle.
// Synchronous active-high reset clears the sequencer and output valid.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 32,
  parameter int MAX_EXPONENT  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // mode, a_num, a_den, b_num, b_den, exponent
  input  logic [rau_pkg::DATA_W-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // res_num, res_den, order, status, zero pad
  output logic [rau_pkg::DATA_W-1:0] m_tdata
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int EW = $clog2(MAX_EXPONENT + 1);
  localparam logic signed [6:0] EMAX = 7'(MAX_EXPONENT);

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
  endfunction

  state_t      state, state_next;
  iter_req_t   req;
  iter_rsp_t   rsp;
  logic [63:0] ux, uy, ures;

  logic [2:0]   mode;
  logic [W-1:0] an, ad, bn, bd;
  logic         aneg, bneg, neg, pw, ovf, eneg, eodd;
  logic [EW-1:0] ecnt;
  logic [63:0]  n, d, t;
  logic [1:0]   st, ord;

  // input decode
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic         in_aneg, in_bneg;
  logic signed [6:0] es, elim, eabs;
  logic         uses_b;
  logic         n_ovf;

  assign in_an   = mag_of(s_tdata[3+W-1:3]);
  assign in_ad   = mag_of(s_tdata[35+W-1:35]);
  assign in_bn   = mag_of(s_tdata[67+W-1:67]);
  assign in_bd   = mag_of(s_tdata[99+W-1:99]);
  assign in_aneg = (s_tdata[3+W-1] != s_tdata[35+W-1]) && (in_an != '0);
  assign in_bneg = (s_tdata[67+W-1] != s_tdata[99+W-1]) && (in_bn != '0);
  assign es      = {{2{s_tdata[135]}}, s_tdata[135:131]};

  always_comb begin
    if (es > EMAX) elim = EMAX;
    else if (es < -EMAX) elim = -EMAX;
    else elim = es;
    eabs = elim[6] ? -elim : elim;
  end

  assign uses_b   = mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP};
  assign n_ovf    = d[63] || (n[63] && !(neg && n == {1'b1, 63'd0}));
  assign s_tready = (state == S_IDLE);

  rau_iter #(.W(W)) u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .x   (ux),
    .y   (uy),
    .rsp (rsp),
    .res (ures)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CHECK;
      S_CHECK: begin
        if (ad == '0 || (uses_b && bd == '0)) begin
          state_next = S_OUT;
        end else begin
          case (mode)
            MODE_DIV: state_next = (bn == '0) ? S_OUT : S_M1;
            MODE_RCP: state_next = (an == '0) ? S_OUT : S_GCD;
            MODE_ABS, MODE_POW: state_next = S_GCD;
            default: state_next = S_M1;
          endcase
        end
      end
      S_M1: if (rsp.done) state_next = S_M2;
      S_M2: begin
        if (rsp.done) begin
          if (mode == MODE_CMP) state_next = S_CMP;
          else if (mode == MODE_ADD || mode == MODE_SUB) state_next = S_M3;
          else state_next = S_GCD;
        end
      end
      S_M3:  if (rsp.done) state_next = S_ADD;
      S_ADD: state_next = S_GCD;
      S_CMP: state_next = S_OUT;
      S_GCD: if (rsp.done) state_next = S_DIVN;
      S_DIVN: if (rsp.done) state_next = S_DIVD;
      S_DIVD: if (rsp.done) state_next = pw ? S_PPREP : S_FIN;
      S_PPREP: state_next = (eneg && an == '0) ? S_OUT : S_PCHK;
      S_PCHK: begin
        if (ovf) state_next = S_OUT;
        else if (ecnt == '0) state_next = S_GCD;
        else state_next = S_PMN;
      end
      S_PMN: if (rsp.done) state_next = S_PMD;
      S_PMD: if (rsp.done) state_next = S_PCHK;
      S_FIN: state_next = S_OUT;
      S_OUT: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.go = 1'b0;
    req.op = OP_MUL;
    ux     = 64'd0;
    uy     = 64'd0;
    case (state)
      S_M1: begin
        req.go = 1'b1;
        ux     = 64'(an);
        uy     = (mode == MODE_MUL) ? 64'(bn) : 64'(bd);
      end
      S_M2: begin
        req.go = 1'b1;
        if (mode == MODE_MUL) begin
          ux = 64'(ad);
          uy = 64'(bd);
        end else if (mode == MODE_DIV) begin
          ux = 64'(ad);
          uy = 64'(bn);
        end else begin
          ux = 64'(bn);
          uy = 64'(ad);
        end
      end
      S_M3: begin
        req.go = 1'b1;
        ux     = 64'(ad);
        uy     = 64'(bd);
      end
      S_GCD: begin
        req.go = 1'b1;
        req.op = OP_GCD;
        ux     = n;
        uy     = d;
      end
      S_DIVN: begin
        req.go = 1'b1;
        req.op = OP_DIV;
        ux     = n;
        uy     = t;
      end
      S_DIVD: begin
        req.go = 1'b1;
        req.op = OP_DIV;
        ux     = d;
        uy     = t;
      end
      S_PMN: begin
        req.go = 1'b1;
        ux     = n;
        uy     = 64'(an);
      end
      S_PMD: begin
        req.go = 1'b1;
        ux     = d;
        uy     = 64'(ad);
      end
      default: req.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode <= s_tdata[2:0];
            an   <= in_an;
            ad   <= in_ad;
            bn   <= in_bn;
            bd   <= in_bd;
            aneg <= in_aneg;
            bneg <= (s_tdata[2:0] == MODE_SUB && in_bn != '0) ? !in_bneg : in_bneg;
            eneg <= elim[6];
            eodd <= eabs[0];
            ecnt <= eabs[EW-1:0];
            st   <= ST_OK;
            ord  <= ORD_LT;
            pw   <= 1'b0;
            ovf  <= 1'b0;
          end
        end
        S_CHECK: begin
          if (ad == '0 || (uses_b && bd == '0)) begin
            st <= ST_UNDEF;
          end else begin
            case (mode)
              MODE_DIV: begin
                if (bn == '0) st <= ST_UNDEF;
                neg <= aneg != bneg;
              end
              MODE_MUL: neg <= aneg != bneg;
              MODE_RCP: begin
                if (an == '0) st <= ST_UNDEF;
                n   <= 64'(ad);
                d   <= 64'(an);
                neg <= aneg;
              end
              MODE_ABS: begin
                n   <= 64'(an);
                d   <= 64'(ad);
                neg <= 1'b0;
              end
              MODE_POW: begin
                n  <= 64'(an);
                d  <= 64'(ad);
                pw <= 1'b1;
              end
              default: neg <= 1'b0;
            endcase
          end
        end
        S_M1: if (rsp.done) n <= ures;
        S_M2: begin
          if (rsp.done) begin
            if (mode == MODE_MUL || mode == MODE_DIV) d <= ures;
            else t <= ures;
          end
        end
        S_M3: if (rsp.done) d <= ures;
        S_ADD: begin
          if (aneg == bneg) begin
            n   <= n + t;
            neg <= aneg;
          end else if (n >= t) begin
            n   <= n - t;
            neg <= aneg;
          end else begin
            n   <= t - n;
            neg <= bneg;
          end
        end
        S_CMP: begin
          if (aneg != bneg) ord <= aneg ? ORD_LT : ORD_GT;
          else if (n == t) ord <= ORD_EQ;
          else if ((n > t) != aneg) ord <= ORD_GT;
          else ord <= ORD_LT;
        end
        S_GCD: if (rsp.done) t <= ures;
        S_DIVN: if (rsp.done) n <= ures;
        S_DIVD: begin
          if (rsp.done) begin
            d <= ures;
            if (pw) begin
              an <= n[W-1:0];
              ad <= ures[W-1:0];
            end
          end
        end
        S_PPREP: begin
          aneg <= aneg && (an != '0);
          if (eneg) begin
            if (an == '0) st <= ST_UNDEF;
            an <= ad;
            ad <= an;
          end
          n   <= 64'd1;
          d   <= 64'd1;
          ovf <= 1'b0;
        end
        S_PCHK: begin
          if (ovf) begin
            st <= ST_OVF;
          end else if (ecnt == '0) begin
            neg <= aneg && eodd;
            pw  <= 1'b0;
          end
        end
        S_PMN: begin
          if (rsp.done) begin
            n   <= ures;
            ovf <= ovf | rsp.ovf;
          end
        end
        S_PMD: begin
          if (rsp.done) begin
            d    <= ures;
            ovf  <= ovf | rsp.ovf;
            ecnt <= ecnt - {{(EW-1){1'b0}}, 1'b1};
          end
        end
        S_FIN: begin
          neg <= neg && (n != 64'd0);
          if (n_ovf) st <= ST_OVF;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (st != ST_OK) begin
              m_tdata <= {5'd0, st, ORD_LT, 63'd0, 64'd0};
            end else if (mode == MODE_CMP) begin
              m_tdata <= {5'd0, ST_OK, ord, 63'd0, 64'd0};
            end else begin
              m_tdata <= {5'd0, ST_OK, ORD_LT, d[62:0], (neg ? (~n + 64'd1) : n)};
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
